/* rtl/vector_dot_and_norm_macros.svh */
// Assertion macros shared by the vector dot and norm RTL.
`ifndef VECTOR_DOT_AND_NORM_MACROS_SVH
`define VECTOR_DOT_AND_NORM_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define VDN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define VDN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VDN_ASSERT(label, clk, rst, prop, msg)
`define VDN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/vdn_pkg.sv */
// Package with types and constants for the vector dot and norm block.
`timescale 1ns / 1ps
package vdn_pkg;

   // Significant bits of each element; upper bits of the input are ignored.
   localparam int ElementBits = 32;
   localparam int ElemShift   = 32 - ElementBits;

   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   localparam logic [63:0] AccMax       = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] AccMin       = 64'h8000_0000_0000_0000;
   localparam logic [63:0] RootFirstBit = 64'h4000_0000_0000_0000;

   localparam logic CmdDot   = 1'b0;
   localparam logic CmdNorm  = 1'b1;
   localparam logic KindDot  = 1'b0;
   localparam logic KindNorm = 1'b1;

   typedef struct packed {
      logic               norm;
      logic               last;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } elem_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      ST_RUN,
      ST_ROOT
   } back_state_type;

endpackage

/* rtl/vdn_front.sv */
// Front end: takes element transfers, sign-extends them and picks the second factor.
`timescale 1ns / 1ps
module vdn_front import vdn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_command,
   input  logic [31:0]      req_x_value,
   input  logic [31:0]      req_y_value,
   input  logic             req_last_element,
   input  queue_status_type q_status,
   output logic             q_push,
   output elem_type         q_elem
);

   logic               hold_valid_ff, hold_valid_in;
   elem_type           hold_elem_ff, hold_elem_in;
   logic signed [31:0] x_shl, y_shl, x_ext, y_ext;

   assign q_push    = hold_valid_ff && !q_status.full;
   assign req_stall = hold_valid_ff && q_status.full;
   assign q_elem    = hold_elem_ff;

   always_comb begin
      // keep the low ElementBits bits, sign-extended
      x_shl = $signed(req_x_value) <<< ElemShift;
      y_shl = $signed(req_y_value) <<< ElemShift;
      x_ext = x_shl >>> ElemShift;
      y_ext = y_shl >>> ElemShift;

      hold_valid_in = hold_valid_ff;
      hold_elem_in  = hold_elem_ff;
      if (!req_stall) begin
         hold_valid_in     = req_valid;
         hold_elem_in.norm = req_command;
         hold_elem_in.last = req_last_element;
         hold_elem_in.x    = x_ext;
         hold_elem_in.y    = (req_command == CmdNorm) ? x_ext : y_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_elem_ff <= hold_elem_in;
   end

endmodule

/* rtl/vdn_queue.sv */
// Short element queue between the front end and the back end.
`timescale 1ns / 1ps
`include "vector_dot_and_norm_macros.svh"
module vdn_queue import vdn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  elem_type         push_elem,
   input  logic             pop,
   output elem_type         pop_elem,
   output queue_status_type status
);

   elem_type                 slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == QueueCntBits'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign pop_elem     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_elem;
      end
   end

   `VDN_ASSERT(a_queue_count_bound, clock, reset, count_ff <= QueueCntBits'(QueueDepth), "queue count beyond depth")

endmodule

/* rtl/vdn_back.sv */
// Back end: multiplier stage, saturating accumulator, square-root unit and result register.
`timescale 1ns / 1ps
`include "vector_dot_and_norm_macros.svh"
module vdn_back import vdn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  elem_type         q_elem,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_result_value,
   output logic             rsp_result_kind,
   output logic             rsp_saturated
);

   back_state_type     state_ff, state_in;

   logic               mul_valid_ff, mul_valid_in;
   logic               mul_norm_ff, mul_norm_in;
   logic               mul_last_ff, mul_last_in;
   logic signed [63:0] mul_prod_ff, mul_prod_in;

   logic [63:0]        acc_ff, acc_in;
   logic               ovf_ff, ovf_in;

   logic [63:0]        rad_ff, rad_in;
   logic [63:0]        root_ff, root_in;
   logic [63:0]        bit_ff, bit_in;
   logic               root_sat_ff, root_sat_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic               out_free, mul_take, mul_adv, start_root, dot_out, root_out;
   logic signed [31:0] fac_x, fac_y;
   logic [64:0]        wide_sum;
   logic               sum_ovf;
   logic [63:0]        sat_sum;
   logic [63:0]        trial;

   // control
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      mul_take   = mul_valid_ff && (state_ff == ST_RUN) &&
                   (!mul_last_ff || (mul_norm_ff == CmdNorm) || out_free);
      mul_adv    = !mul_valid_ff || mul_take;
      q_pop      = mul_adv && !q_status.empty;
      start_root = mul_take && mul_last_ff && (mul_norm_ff == CmdNorm);
      dot_out    = mul_take && mul_last_ff && (mul_norm_ff == CmdDot);
      root_out   = (state_ff == ST_ROOT) && (bit_ff == '0) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:  if (start_root) state_in = ST_ROOT;
         ST_ROOT: if (root_out) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   // datapath
   always_comb begin
      fac_x       = q_elem.x;
      fac_y       = q_elem.y;
      mul_valid_in = mul_adv ? !q_status.empty : mul_valid_ff;
      mul_norm_in  = mul_norm_ff;
      mul_last_in  = mul_last_ff;
      mul_prod_in  = mul_prod_ff;
      if (q_pop) begin
         mul_norm_in = q_elem.norm;
         mul_last_in = q_elem.last;
         mul_prod_in = fac_x * fac_y;
      end

      wide_sum = {acc_ff[63], acc_ff} + {mul_prod_ff[63], mul_prod_ff};
      sum_ovf  = wide_sum[64] ^ wide_sum[63];
      sat_sum  = sum_ovf ? (wide_sum[64] ? AccMin : AccMax) : wide_sum[63:0];

      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (mul_take) begin
         if (mul_last_ff) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = sat_sum;
            ovf_in = ovf_ff | sum_ovf;
         end
      end

      trial       = root_ff + bit_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      root_sat_in = root_sat_ff;
      if (start_root) begin
         // a negative sum takes the root of zero
         rad_in      = sat_sum[63] ? '0 : sat_sum;
         root_in     = '0;
         bit_in      = RootFirstBit;
         root_sat_in = ovf_ff | sum_ovf;
      end else if ((state_ff == ST_ROOT) && (bit_ff != '0)) begin
         if (rad_ff >= trial) begin
            rad_in  = rad_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (dot_out) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = sat_sum;
         rsp_kind_in  = KindDot;
         rsp_sat_in   = ovf_ff | sum_ovf;
      end else if (root_out) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = root_ff;
         rsp_kind_in  = KindNorm;
         rsp_sat_in   = root_sat_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         mul_valid_ff <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_valid_ff <= mul_valid_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_norm_ff  <= mul_norm_in;
      mul_last_ff  <= mul_last_in;
      mul_prod_ff  <= mul_prod_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      root_sat_ff  <= root_sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_saturated    = rsp_sat_ff;

   `VDN_ASSERT(a_root_idle_in_run, clock, reset, (state_ff == ST_RUN) |-> (bit_ff == '0), "root unit busy outside root state")
   `VDN_ASSERT(a_acc_clear_on_root, clock, reset, $rose(state_ff == ST_ROOT) |-> ((acc_ff == '0) && !ovf_ff), "accumulator not cleared at end of vector")
   `VDN_ASSERT(a_norm_result_narrow, clock, reset, (rsp_valid_ff && (rsp_kind_ff == KindNorm)) |-> (rsp_value_ff[63:32] == '0), "norm result wider than Q16.16")

endmodule

/* rtl/vector_dot_and_norm.sv */
// Top level of the streaming dot product and Euclidean norm block.
`timescale 1ns / 1ps
// Streams one element pair per transfer in signed Q16.16 and accumulates the
// Q32.32 products in a saturating 64-bit sum; the element marked last yields
// one result (dot: signed Q32.32 sum, norm: unsigned Q16.16 integer square
// root) together with a sticky saturation flag, and the sum then clears.
// While a vector accumulates, the block takes one element per cycle unless
// the queue is full. A dot result reaches the result port through the front
// register, the queue, the multiplier register and the result register. A
// norm result also passes through the bit-pair square-root unit, during which
// the back end holds; the multiplier register, the four-entry queue and the
// front register keep taking up to six further elements meanwhile.
module vector_dot_and_norm import vdn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_x_value,
   input  logic [31:0] req_y_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic        rsp_result_kind,
   output logic        rsp_saturated
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   elem_type         push_elem, pop_elem;

   vdn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_last_element (req_last_element),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_elem           (push_elem)
   );

   vdn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_elem (push_elem),
      .pop       (q_pop),
      .pop_elem  (pop_elem),
      .status    (q_status)
   );

   vdn_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_elem           (pop_elem),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
